>>> design/comp_pkg.sv
// Shared types and constants for the channel-open message parser.
package comp_pkg;

	// Header slots in a message, and how many headers are forwarded
	localparam int unsigned NUM_SLOTS   = 4;
	localparam int unsigned MAX_HEADERS = 4;

	// Configuration register reset values
	localparam logic [15:0] MAX_COLUMNS_RST  = 16'd4096;
	localparam logic [15:0] MAX_NAME_LEN_RST = 16'd1024;

	// Configuration register indexes
	localparam logic [7:0] CFG_MAX_COLUMNS  = 8'd0;
	localparam logic [7:0] CFG_MAX_NAME_LEN = 8'd1;

	// Parse phase
	typedef enum logic [3:0] {
		PH_IDLE     = 4'd0,
		PH_TEMPLATE = 4'd1,
		PH_CHANID   = 4'd2,
		PH_SLOTLEN  = 4'd3,
		PH_HDR_FWD  = 4'd4,
		PH_HDR_SKIP = 4'd5,
		PH_COLCOUNT = 4'd6,
		PH_COLLEN   = 4'd7,
		PH_COLNAME  = 4'd8
	} phase_t;

	// Result kinds
	typedef enum logic [3:0] {
		K_TEMPLATE_ID = 4'd0,
		K_CHANNEL_ID  = 4'd1,
		K_HDR_START   = 4'd2,
		K_HDR_BYTE    = 4'd3,
		K_DONE        = 4'd4,
		K_VARINT_ERR  = 4'd5,
		K_COLCNT_ERR  = 4'd6,
		K_NAMELEN_ERR = 4'd7,
		K_INCOMPLETE  = 4'd8
	} kind_t;

	// Varint decoder status for one byte
	typedef enum logic [1:0] {
		VI_MORE = 2'd0,
		VI_DONE = 2'd1,
		VI_ERR  = 2'd2
	} vstat_t;

	// One result item
	typedef struct packed {
		kind_t       kind;
		logic [63:0] value;
		logic [1:0]  idx;
		logic        last;
	} res_t;

	// Results produced by one item, pushed into the result queue
	typedef struct packed {
		logic [1:0] cnt;
		res_t       r0;
		res_t       r1;
	} push_t;

endpackage

>>> design/comp_varint.sv
// Base-128 varint byte step: folds one byte into the running value.
module comp_varint import comp_pkg::*; (
	input  logic [63:0] acc,
	input  logic [3:0]  cnt,
	input  logic [7:0]  b,
	output vstat_t      status,
	output logic [63:0] acc_next,
	output logic [3:0]  cnt_next
);

	logic [5:0]  shamt;
	logic [63:0] group;

	assign shamt = 6'({2'b00, cnt} * 6'd7);
	assign group = {57'd0, b[6:0]} << shamt;

	always_comb begin
		status   = VI_MORE;
		acc_next = acc;
		cnt_next = 4'd0;
		if (cnt >= 4'd9) begin
			// tenth byte: only bit 0 may be set, and it is value bit 63
			if (b[7:1] != 7'd0) begin
				status = VI_ERR;
			end else begin
				status   = VI_DONE;
				acc_next = acc | {b[0], 63'd0};
			end
		end else begin
			acc_next = acc | group;
			if (b[7]) begin
				cnt_next = cnt + 4'd1;
			end else begin
				status = VI_DONE;
			end
		end
	end

endmodule

>>> design/comp_core.sv
// Parser core: input register, parse state, config registers, result generation.
module comp_core import comp_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_ready,
	input  logic [7:0]  data_byte,
	input  logic        first_byte,
	input  logic        opcode,
	input  logic        end_of_data,
	input  logic        cfg_valid,
	input  logic [7:0]  cfg_index,
	input  logic [15:0] cfg_data,
	input  logic        room,
	output push_t       push
);

	// input stage
	logic       valid_s1;
	logic [7:0] byte_s1;
	logic       start_s1, opc_s1, eod_s1;
	logic       fire;

	// parse state
	phase_t      phase_q;
	logic        clone_q;
	logic [63:0] acc_q;
	logic [3:0]  cnt_q;
	logic [2:0]  slot_q;
	logic [2:0]  hc_q;
	logic [63:0] br_q;
	logic [15:0] cr_q;
	logic [15:0] max_columns_q, max_name_len_q;

	// state after a message start is applied
	phase_t      ph_e;
	logic        clone_e;
	logic [63:0] acc_e;
	logic [3:0]  cnt_e;
	logic [2:0]  slot_e;
	logic [2:0]  hc_e;
	logic [63:0] br_e;
	logic [15:0] cr_e;

	// next state
	phase_t      ph_n;
	logic [63:0] acc_n;
	logic [3:0]  cnt_n;
	logic [2:0]  slot_n;
	logic [2:0]  hc_n;
	logic [63:0] br_n;
	logic [15:0] cr_n;

	// shared decode
	vstat_t      vst;
	logic [63:0] v, acc_nx;
	logic [3:0]  cnt_nx;
	logic [63:0] v_m1, br_m1;
	logic [15:0] cr_m1;
	logic [2:0]  slot_inc;
	phase_t      slot_ph;
	logic        hdr_room;
	res_t        body;
	logic        body_v;
	logic        eod_rep;
	phase_t      ph_pre;

	assign fire     = valid_s1 && room;
	assign in_ready = !valid_s1 || room;

	// input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ready) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			byte_s1  <= data_byte;
			start_s1 <= first_byte;
			opc_s1   <= opcode;
			eod_s1   <= end_of_data;
		end
	end

	// config registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			max_columns_q  <= MAX_COLUMNS_RST;
			max_name_len_q <= MAX_NAME_LEN_RST;
		end else if (cfg_valid) begin
			unique case (cfg_index)
				CFG_MAX_COLUMNS:  max_columns_q  <= cfg_data;
				CFG_MAX_NAME_LEN: max_name_len_q <= cfg_data;
				default: ;
			endcase
		end
	end

	// message start clears the parse state
	always_comb begin
		if (start_s1) begin
			ph_e    = opc_s1 ? PH_TEMPLATE : PH_CHANID;
			clone_e = opc_s1;
			acc_e   = 64'd0;
			cnt_e   = 4'd0;
			slot_e  = 3'd0;
			hc_e    = 3'd0;
			br_e    = 64'd0;
			cr_e    = 16'd0;
		end else begin
			ph_e    = phase_q;
			clone_e = clone_q;
			acc_e   = acc_q;
			cnt_e   = cnt_q;
			slot_e  = slot_q;
			hc_e    = hc_q;
			br_e    = br_q;
			cr_e    = cr_q;
		end
	end

	comp_varint u_varint (
		.acc      (acc_e),
		.cnt      (cnt_e),
		.b        (byte_s1),
		.status   (vst),
		.acc_next (acc_nx),
		.cnt_next (cnt_nx)
	);

	assign v        = acc_nx;
	assign v_m1     = v - 64'd1;
	assign br_m1    = br_e - 64'd1;
	assign cr_m1    = cr_e - 16'd1;
	assign slot_inc = slot_e + 3'd1;
	assign slot_ph  = (slot_inc >= 3'(NUM_SLOTS)) ? PH_COLCOUNT : PH_SLOTLEN;
	assign hdr_room = hc_e < 3'(MAX_HEADERS);

	// next state
	always_comb begin
		ph_n   = ph_e;
		acc_n  = acc_e;
		cnt_n  = cnt_e;
		slot_n = slot_e;
		hc_n   = hc_e;
		br_n   = br_e;
		cr_n   = cr_e;
		case (ph_e)
			PH_TEMPLATE, PH_CHANID, PH_SLOTLEN, PH_COLCOUNT, PH_COLLEN: begin
				acc_n = acc_nx;
				cnt_n = cnt_nx;
				if (vst == VI_ERR) begin
					ph_n = PH_IDLE;
				end else if (vst == VI_DONE) begin
					acc_n = 64'd0;
					case (ph_e)
						PH_TEMPLATE: ph_n = PH_CHANID;
						PH_CHANID: begin
							slot_n = 3'd0;
							ph_n   = PH_SLOTLEN;
						end
						PH_SLOTLEN: begin
							if (v == 64'd0) begin
								slot_n = slot_inc;
								ph_n   = slot_ph;
							end else begin
								br_n = v_m1;
								if (hdr_room) begin
									hc_n = hc_e + 3'd1;
									ph_n = PH_HDR_FWD;
								end else begin
									ph_n = PH_HDR_SKIP;
								end
								// header length one: nothing to forward
								if (v_m1 == 64'd0) begin
									slot_n = slot_inc;
									ph_n   = slot_ph;
								end
							end
						end
						PH_COLCOUNT: begin
							if (v > {48'd0, max_columns_q} || v == 64'd0) begin
								ph_n = PH_IDLE;
							end else begin
								cr_n = v[15:0];
								ph_n = PH_COLLEN;
							end
						end
						default: begin
							if (v > {48'd0, max_name_len_q}) begin
								ph_n = PH_IDLE;
							end else if (v == 64'd0) begin
								cr_n = cr_m1;
								ph_n = (cr_m1 == 16'd0) ? PH_IDLE : PH_COLLEN;
							end else begin
								br_n = v;
								ph_n = PH_COLNAME;
							end
						end
					endcase
				end
			end
			PH_HDR_FWD, PH_HDR_SKIP: begin
				br_n = br_m1;
				if (br_m1 == 64'd0) begin
					slot_n = slot_inc;
					ph_n   = slot_ph;
				end
			end
			PH_COLNAME: begin
				br_n = br_m1;
				if (br_m1 == 64'd0) begin
					cr_n = cr_m1;
					ph_n = (cr_m1 == 16'd0) ? PH_IDLE : PH_COLLEN;
				end
			end
			default: ph_n = PH_IDLE;
		endcase
		// end of data inside a message
		if (eod_s1 && ph_n != PH_IDLE) begin
			ph_n  = PH_IDLE;
			acc_n = 64'd0;
			cnt_n = 4'd0;
		end
	end

	// result of the byte itself
	always_comb begin
		body_v     = 1'b0;
		body.kind  = K_DONE;
		body.value = 64'd0;
		body.idx   = 2'd0;
		body.last  = 1'b0;
		case (ph_e)
			PH_TEMPLATE, PH_CHANID, PH_SLOTLEN, PH_COLCOUNT, PH_COLLEN: begin
				if (vst == VI_ERR) begin
					body_v    = 1'b1;
					body.kind = K_VARINT_ERR;
				end else if (vst == VI_DONE) begin
					case (ph_e)
						PH_TEMPLATE: begin
							body_v     = 1'b1;
							body.kind  = K_TEMPLATE_ID;
							body.value = v;
						end
						PH_CHANID: begin
							body_v     = 1'b1;
							body.kind  = K_CHANNEL_ID;
							body.value = v;
						end
						PH_SLOTLEN: begin
							if (v != 64'd0 && hdr_room) begin
								body_v     = 1'b1;
								body.kind  = K_HDR_START;
								body.value = v_m1;
								body.idx   = hc_e[1:0];
							end
						end
						PH_COLCOUNT: begin
							if (v > {48'd0, max_columns_q}) begin
								body_v    = 1'b1;
								body.kind = K_COLCNT_ERR;
							end else if (v == 64'd0) begin
								body_v    = 1'b1;
								body.kind = K_DONE;
							end
						end
						default: begin
							if (v > {48'd0, max_name_len_q}) begin
								body_v    = 1'b1;
								body.kind = K_NAMELEN_ERR;
							end else if (v == 64'd0 && cr_m1 == 16'd0) begin
								body_v    = 1'b1;
								body.kind = K_DONE;
							end
						end
					endcase
				end
			end
			PH_HDR_FWD: begin
				body_v     = 1'b1;
				body.kind  = K_HDR_BYTE;
				body.value = {56'd0, byte_s1};
				body.idx   = 2'(hc_e - 3'd1);
			end
			PH_COLNAME: begin
				if (br_m1 == 64'd0 && cr_m1 == 16'd0) begin
					body_v    = 1'b1;
					body.kind = K_DONE;
				end
			end
			default: ;
		endcase
	end

	// pack results: byte result first, then incomplete report
	always_comb begin
		push.r0 = body;
		push.r1 = body;
		push.r1.kind  = K_INCOMPLETE;
		push.r1.value = 64'd0;
		push.r1.idx   = 2'd0;
		push.r1.last  = 1'b1;
		eod_rep = eod_s1 && (ph_pre != PH_IDLE);
		if (!fire) begin
			push.cnt = 2'd0;
		end else if (body_v && eod_rep) begin
			push.cnt = 2'd2;
		end else if (body_v) begin
			push.cnt     = 2'd1;
			push.r0.last = 1'b1;
		end else if (eod_rep) begin
			push.cnt = 2'd1;
			push.r0  = push.r1;
		end else begin
			push.cnt = 2'd0;
		end
	end

	// phase before the end-of-data override, kept apart for the report
	always_comb begin
		ph_pre = ph_e;
		case (ph_e)
			PH_TEMPLATE, PH_CHANID, PH_SLOTLEN, PH_COLCOUNT, PH_COLLEN: begin
				if (vst == VI_ERR) begin
					ph_pre = PH_IDLE;
				end else if (vst == VI_DONE) begin
					case (ph_e)
						PH_COLCOUNT: begin
							if (v > {48'd0, max_columns_q} || v == 64'd0) begin
								ph_pre = PH_IDLE;
							end
						end
						PH_COLLEN: begin
							if (v > {48'd0, max_name_len_q}) begin
								ph_pre = PH_IDLE;
							end else if (v == 64'd0 && cr_m1 == 16'd0) begin
								ph_pre = PH_IDLE;
							end
						end
						default: ;
					endcase
				end
			end
			PH_COLNAME: begin
				if (br_m1 == 64'd0 && cr_m1 == 16'd0) begin
					ph_pre = PH_IDLE;
				end
			end
			default: ;
		endcase
	end

	// state registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= PH_IDLE;
			clone_q <= 1'b0;
			acc_q   <= 64'd0;
			cnt_q   <= 4'd0;
			slot_q  <= 3'd0;
			hc_q    <= 3'd0;
			br_q    <= 64'd0;
			cr_q    <= 16'd0;
		end else if (fire) begin
			phase_q <= ph_n;
			clone_q <= clone_e;
			acc_q   <= acc_n;
			cnt_q   <= cnt_n;
			slot_q  <= slot_n;
			hc_q    <= hc_n;
			br_q    <= br_n;
			cr_q    <= cr_n;
		end
	end

endmodule

>>> design/comp_fifo.sv
// Result queue: four entries, takes up to two results per cycle, gives one.
module comp_fifo import comp_pkg::*; (
	input  logic  clk,
	input  logic  arst_n,
	input  push_t push,
	output logic  room,
	output logic  out_valid,
	input  logic  out_ready,
	output res_t  head
);

	res_t       mem [4];
	logic [1:0] wr_q, rd_q;
	logic [2:0] count_q;
	logic       pop;

	assign pop       = out_valid && out_ready;
	assign out_valid = count_q != 3'd0;
	assign room      = count_q <= 3'd2;
	assign head      = mem[rd_q];

	// entry writes
	always_ff @(posedge clk) begin
		if (push.cnt != 2'd0) begin
			mem[wr_q] <= push.r0;
		end
		if (push.cnt == 2'd2) begin
			mem[wr_q + 2'd1] <= push.r1;
		end
	end

	// pointers and fill count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q    <= 2'd0;
			rd_q    <= 2'd0;
			count_q <= 3'd0;
		end else begin
			wr_q    <= wr_q + push.cnt;
			rd_q    <= rd_q + {1'b0, pop};
			count_q <= count_q + {1'b0, push.cnt} - {2'b00, pop};
		end
	end

endmodule

>>> design/channel_open_message_parser.sv
// Top level of the channel-open message parser.
// A result passes the input register and then the result queue before it reaches the outputs.
// Throughput: one item per cycle while the receiver keeps taking results and items give at
// most one result each; the output gives one result per cycle, so two-result items stall
// the input once the queue holds three.
// Reset (arst_n low, asynchronous): parser waits for a message start, config at
// max_columns 4096 and max_name_len 1024, result queue empty.
module channel_open_message_parser import comp_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_ready,
	input  logic [7:0]  data_byte,
	input  logic        first_byte,
	input  logic        opcode,
	input  logic        end_of_data,
	output logic        out_valid,
	input  logic        out_ready,
	output logic [3:0]  kind,
	output logic [63:0] value,
	output logic [1:0]  header_index,
	output logic        last_of_run,
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic [7:0]  cfg_index,
	input  logic [15:0] cfg_data
);

	push_t push;
	logic  room;
	res_t  head;

	// config writes are always taken
	assign cfg_ready = 1'b1;

	comp_core u_core (
		.clk         (clk),
		.arst_n      (arst_n),
		.in_valid    (in_valid),
		.in_ready    (in_ready),
		.data_byte   (data_byte),
		.first_byte  (first_byte),
		.opcode      (opcode),
		.end_of_data (end_of_data),
		.cfg_valid   (cfg_valid),
		.cfg_index   (cfg_index),
		.cfg_data    (cfg_data),
		.room        (room),
		.push        (push)
	);

	comp_fifo u_fifo (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.room      (room),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.head      (head)
	);

	assign kind         = head.kind;
	assign value        = head.value;
	assign header_index = head.idx;
	assign last_of_run  = head.last;

endmodule

>>> tb/sv/open_msg_check.sv
// Watches the parser's channels, predicts every result and compares in order.
`timescale 1ns / 1ps
module open_msg_check import comp_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	input  logic        in_ready,
	input  logic [7:0]  data_byte,
	input  logic        first_byte,
	input  logic        opcode,
	input  logic        end_of_data,
	input  logic        out_valid,
	input  logic        out_ready,
	input  logic [3:0]  kind,
	input  logic [63:0] value,
	input  logic [1:0]  header_index,
	input  logic        last_of_run,
	input  logic        cfg_valid,
	input  logic        cfg_ready,
	input  logic [7:0]  cfg_index,
	input  logic [15:0] cfg_data,
	output int          mismatches,
	output int          events_due
);

	// Limits as the parser holds them
	logic [15:0] col_limit;
	logic [15:0] name_limit;

	// Parser state mirror
	phase_t      ps;
	logic        clone_msg;
	logic [63:0] acc;
	logic [3:0]  acc_bytes;
	logic [2:0]  slot;
	logic [2:0]  hdr_cnt;
	logic [63:0] left;
	logic [15:0] cols_left;

	// Events owed by the parser, oldest first
	res_t parse_events_due[$];
	res_t step_res[2];
	int   step_n;

	function automatic void note(kind_t k, logic [63:0] v, logic [2:0] i);
		res_t r;
		r.kind  = k;
		r.value = v;
		r.idx   = i[1:0];
		r.last  = 1'b0;
		step_res[step_n] = r;
		step_n = step_n + 1;
	endfunction

	// One byte into the base-128 accumulator; tenth byte may only carry bit 63
	function automatic vstat_t feed_varint(logic [7:0] b);
		if (acc_bytes >= 4'd9) begin
			acc_bytes = 4'd0;
			if (b[7:1] != 7'd0)
				return VI_ERR;
			acc[63] = acc[63] | b[0];
			return VI_DONE;
		end
		acc = acc | ({57'd0, b[6:0]} << (7 * acc_bytes));
		if (!b[7]) begin
			acc_bytes = 4'd0;
			return VI_DONE;
		end
		acc_bytes = acc_bytes + 4'd1;
		return VI_MORE;
	endfunction

	function automatic void next_slot();
		slot = slot + 3'd1;
		if (slot >= NUM_SLOTS)
			ps = PH_COLCOUNT;
		else
			ps = PH_SLOTLEN;
	endfunction

	function automatic void column_done();
		cols_left = cols_left - 16'd1;
		if (cols_left == 16'd0) begin
			ps = PH_IDLE;
			note(K_DONE, 64'd0, 3'd0);
		end else begin
			ps = PH_COLLEN;
		end
	endfunction

	// Advance the parse by one accepted byte and queue what it reports
	task automatic parse_byte(logic [7:0] b, logic start, logic op, logic eod);
		vstat_t      st;
		logic [63:0] v;
		res_t        r;
		step_n = 0;
		if (start) begin
			clone_msg = op;
			if (op)
				ps = PH_TEMPLATE;
			else
				ps = PH_CHANID;
			acc       = 64'd0;
			acc_bytes = 4'd0;
			slot      = 3'd0;
			hdr_cnt   = 3'd0;
			left      = 64'd0;
			cols_left = 16'd0;
		end
		case (ps)
			PH_TEMPLATE, PH_CHANID, PH_SLOTLEN, PH_COLCOUNT, PH_COLLEN: begin
				st = feed_varint(b);
				if (st == VI_ERR) begin
					ps = PH_IDLE;
					note(K_VARINT_ERR, 64'd0, 3'd0);
				end else if (st == VI_DONE) begin
					v   = acc;
					acc = 64'd0;
					case (ps)
						PH_TEMPLATE: begin
							note(K_TEMPLATE_ID, v, 3'd0);
							ps = PH_CHANID;
						end
						PH_CHANID: begin
							note(K_CHANNEL_ID, v, 3'd0);
							slot = 3'd0;
							ps   = PH_SLOTLEN;
						end
						PH_SLOTLEN: begin
							if (v == 64'd0) begin
								next_slot();
							end else begin
								left = v - 64'd1;
								if (hdr_cnt < MAX_HEADERS) begin
									note(K_HDR_START, left, hdr_cnt);
									hdr_cnt = hdr_cnt + 3'd1;
									ps = PH_HDR_FWD;
								end else begin
									ps = PH_HDR_SKIP;
								end
								if (left == 64'd0)
									next_slot();
							end
						end
						PH_COLCOUNT: begin
							if (v > {48'd0, col_limit}) begin
								ps = PH_IDLE;
								note(K_COLCNT_ERR, 64'd0, 3'd0);
							end else if (v == 64'd0) begin
								ps = PH_IDLE;
								note(K_DONE, 64'd0, 3'd0);
							end else begin
								cols_left = v[15:0];
								ps = PH_COLLEN;
							end
						end
						default: begin
							if (v > {48'd0, name_limit}) begin
								ps = PH_IDLE;
								note(K_NAMELEN_ERR, 64'd0, 3'd0);
							end else if (v == 64'd0) begin
								column_done();
							end else begin
								left = v;
								ps = PH_COLNAME;
							end
						end
					endcase
				end
			end
			PH_HDR_FWD, PH_HDR_SKIP: begin
				if (ps == PH_HDR_FWD)
					note(K_HDR_BYTE, {56'd0, b}, hdr_cnt - 3'd1);
				left = left - 64'd1;
				if (left == 64'd0)
					next_slot();
			end
			PH_COLNAME: begin
				left = left - 64'd1;
				if (left == 64'd0)
					column_done();
			end
			default: ps = PH_IDLE;
		endcase

		// End of data cuts an open message short
		if (eod && ps != PH_IDLE) begin
			ps        = PH_IDLE;
			acc       = 64'd0;
			acc_bytes = 4'd0;
			note(K_INCOMPLETE, 64'd0, 3'd0);
		end

		for (int i = 0; i < step_n; i++) begin
			r = step_res[i];
			r.last = (i == step_n - 1);
			parse_events_due.push_back(r);
		end
	endtask

	always @(posedge clk or negedge arst_n) begin : watch
		res_t want;
		if (!arst_n) begin
			col_limit  = MAX_COLUMNS_RST;
			name_limit = MAX_NAME_LEN_RST;
			ps         = PH_IDLE;
			clone_msg  = 1'b0;
			acc        = 64'd0;
			acc_bytes  = 4'd0;
			slot       = 3'd0;
			hdr_cnt    = 3'd0;
			left       = 64'd0;
			cols_left  = 16'd0;
			parse_events_due.delete();
			mismatches = 0;
			events_due <= 0;
		end else begin
			// register writes
			if (cfg_valid && cfg_ready) begin
				if (cfg_index == CFG_MAX_COLUMNS)
					col_limit = cfg_data;
				else if (cfg_index == CFG_MAX_NAME_LEN)
					name_limit = cfg_data;
			end

			// result items against the oldest owed event
			if (out_valid && out_ready) begin
				if (parse_events_due.size() == 0) begin
					mismatches = mismatches + 1;
					$error("unexpected result item: kind %0d value %0h", kind, value);
				end else begin
					want = parse_events_due.pop_front();
					if (kind !== want.kind) begin
						mismatches = mismatches + 1;
						$error("kind: expected %0d, actual %0d", want.kind, kind);
					end
					if (value !== want.value) begin
						mismatches = mismatches + 1;
						$error("value: expected %0h, actual %0h", want.value, value);
					end
					if (header_index !== want.idx) begin
						mismatches = mismatches + 1;
						$error("header_index: expected %0d, actual %0d", want.idx, header_index);
					end
					if (last_of_run !== want.last) begin
						mismatches = mismatches + 1;
						$error("last_of_run: expected %0d, actual %0d", want.last, last_of_run);
					end
				end
			end

			// input items
			if (in_valid && in_ready)
				parse_byte(data_byte, first_byte, opcode, end_of_data);

			events_due <= parse_events_due.size();
		end
	end

endmodule

>>> tb/sv/testbench.sv
// Stimulus and verdict for the channel-open message parser regression.
`timescale 1ns / 1ps
module testbench;
	import comp_pkg::*;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        in_valid = 1'b0;
	logic        in_ready;
	logic [7:0]  data_byte = 8'd0;
	logic        first_byte = 1'b0;
	logic        opcode = 1'b0;
	logic        end_of_data = 1'b0;
	logic        out_valid;
	logic        out_ready = 1'b0;
	logic [3:0]  kind;
	logic [63:0] value;
	logic [1:0]  header_index;
	logic        last_of_run;
	logic        cfg_valid = 1'b0;
	logic        cfg_ready;
	logic [7:0]  cfg_index = 8'd0;
	logic [15:0] cfg_data = 16'd0;
	int          mismatches;
	int          events_due;

	channel_open_message_parser dut (.*);
	open_msg_check parse_check (.*);

	// One input item as driven
	typedef struct packed {
		logic [7:0] data;
		logic       start;
		logic       op;
		logic       eod;
	} stim_t;

	stim_t       msg_bytes[$];
	logic        pend_start;
	logic        pend_op;
	int          msg_len;
	int          msg_bad_at;
	int          msg_varints;
	bit          msg_dead;
	logic [15:0] cols_cap;
	logic [15:0] name_cap;
	int          in_gap_pct;
	int          out_gap_pct;
	bit          calm;

	initial begin
		forever #5 clk = ~clk;
	end

	// Run limit
	initial begin
		#5_000_000;
		$display("channel_open_message_parser regression: fail");
		$finish;
	end

	// Receiver stalls in bursts
	initial begin
		forever begin
			@(posedge clk);
			if (!calm && $urandom_range(0, 99) < out_gap_pct) begin
				out_ready <= 1'b0;
				repeat ($urandom_range(1, 10)) @(posedge clk);
			end
			out_ready <= 1'b1;
		end
	end

	function automatic logic [63:0] rand_wide();
		logic [63:0] v;
		int          n;
		v = {$urandom, $urandom};
		n = $urandom_range(0, 64);
		if (n < 64)
			v = v & ((64'd1 << n) - 64'd1);
		return v;
	endfunction

	task automatic add_byte(input logic [7:0] b);
		stim_t s;
		s.data  = b;
		s.start = pend_start;
		s.op    = pend_start ? pend_op : 1'($urandom);
		s.eod   = 1'b0;
		pend_start = 1'b0;
		msg_bytes.push_back(s);
	endtask

	task automatic mark_eod();
		stim_t s;
		s = msg_bytes[msg_bytes.size() - 1];
		s.eod = 1'b1;
		msg_bytes[msg_bytes.size() - 1] = s;
	endtask

	// Shortest encoding mostly, now and then the full ten-byte form
	task automatic add_varint(input logic [63:0] v);
		logic [63:0] rest;
		rest = v;
		if ($urandom_range(0, 9) == 0) begin
			for (int i = 0; i < 9; i++)
				add_byte({1'b1, v[7 * i +: 7]});
			add_byte({7'd0, v[63]});
		end else begin
			do begin
				add_byte({rest > 64'd127, rest[6:0]});
				rest = rest >> 7;
			end while (rest != 64'd0);
		end
	endtask

	// Ten-byte varint whose last byte is illegal
	task automatic add_bad_varint();
		repeat (9) add_byte({1'b1, 7'($urandom)});
		if ($urandom_range(0, 1) != 0)
			add_byte({1'b1, 7'($urandom)});
		else
			add_byte({1'b0, 7'($urandom_range(2, 127))});
	endtask

	task automatic add_field(input logic [63:0] v);
		if (msg_dead)
			return;
		if (msg_varints == msg_bad_at) begin
			add_bad_varint();
			msg_dead = 1'b1;
		end else begin
			add_varint(v);
		end
		msg_varints++;
	endtask

	task automatic add_raw(input int n);
		if (!msg_dead)
			repeat (n) add_byte(8'($urandom));
	endtask

	// One message with random content, sometimes broken
	task automatic build_message(input bit clean);
		int    flaw;
		int    count;
		int    len;
		int    cut;
		int    cols_max;
		int    name_max;
		logic  op;
		stim_t s;
		flaw        = clean ? 15 : $urandom_range(0, 15);
		msg_bad_at  = (flaw == 0) ? $urandom_range(0, 7) : -1;
		msg_varints = 0;
		msg_dead    = 1'b0;
		op          = 1'($urandom);
		pend_start  = 1'b1;
		pend_op     = op;

		if (op)
			add_field(rand_wide());
		add_field(rand_wide());

		// header slots, a third absent
		for (int k = 0; k < NUM_SLOTS; k++) begin
			if ($urandom_range(0, 2) == 0) begin
				add_field(64'd0);
			end else begin
				len = ($urandom_range(0, 15) == 0) ? $urandom_range(7, 40) : $urandom_range(1, 6);
				add_field(64'(len));
				add_raw(len - 1);
			end
		end

		// columns
		cols_max = (cols_cap < 16'd4) ? int'(cols_cap) : 4;
		name_max = (name_cap < 16'd5) ? int'(name_cap) : 5;
		if (flaw == 1) begin
			if ($urandom_range(0, 1) != 0)
				add_field(64'(cols_cap) + 64'd1);
			else
				add_field(rand_wide() | 64'h10000);
		end else begin
			count = $urandom_range(0, cols_max);
			add_field(64'(count));
			for (int k = 0; k < count; k++) begin
				if (flaw == 2 && k == 0) begin
					if ($urandom_range(0, 1) != 0)
						add_field(64'(name_cap) + 64'd1);
					else
						add_field(rand_wide() | 64'h10000);
					break;
				end
				len = $urandom_range(0, name_max);
				add_field(64'(len));
				add_raw(len);
			end
		end
		msg_len = msg_bytes.size();

		case (flaw)
			3, 4: begin
				// cut short; with end of data or left for the next start to drop
				cut = $urandom_range(0, msg_bytes.size() - 1);
				while (msg_bytes.size() > cut + 1)
					void'(msg_bytes.pop_back());
				if (flaw == 3)
					mark_eod();
				msg_len = msg_bytes.size();
			end
			5: mark_eod();
			6: begin
				// stray bytes after the end, ignored
				repeat ($urandom_range(1, 3)) begin
					s.data  = 8'($urandom);
					s.start = 1'b0;
					s.op    = 1'($urandom);
					s.eod   = 1'($urandom);
					msg_bytes.push_back(s);
				end
			end
			default: ;
		endcase
	endtask

	task automatic send_item(input stim_t s);
		if (!calm && $urandom_range(0, 99) < in_gap_pct) begin
			in_valid <= 1'b0;
			repeat ($urandom_range(1, 10)) @(posedge clk);
		end
		in_valid    <= 1'b1;
		data_byte   <= s.data;
		first_byte  <= s.start;
		opcode      <= s.op;
		end_of_data <= s.eod;
		do @(posedge clk); while (!in_ready);
	endtask

	task automatic send_message();
		foreach (msg_bytes[i])
			send_item(msg_bytes[i]);
		msg_bytes.delete();
	endtask

	// Wait until every owed event is out and the pipeline is empty
	task automatic settle();
		in_valid <= 1'b0;
		repeat (4) @(posedge clk);
		while (events_due != 0)
			@(posedge clk);
		repeat (8) @(posedge clk);
	endtask

	task automatic set_limits(input logic [15:0] cols, input logic [15:0] names);
		cfg_valid <= 1'b1;
		cfg_index <= CFG_MAX_COLUMNS;
		cfg_data  <= cols;
		do @(posedge clk); while (!cfg_ready);
		cfg_index <= CFG_MAX_NAME_LEN;
		cfg_data  <= names;
		do @(posedge clk); while (!cfg_ready);
		cfg_valid <= 1'b0;
		cols_cap = cols;
		name_cap = names;
	endtask

	initial begin
		int    items;
		stim_t s;
		cols_cap    = MAX_COLUMNS_RST;
		name_cap    = MAX_NAME_LEN_RST;
		pend_start  = 1'b0;
		pend_op     = 1'b0;
		in_gap_pct  = 0;
		out_gap_pct = 0;
		calm        = 1'b0;
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// stray byte while waiting, with end of data
		s.data  = 8'h00;
		s.start = 1'b0;
		s.op    = 1'b1;
		s.eod   = 1'b1;
		msg_bytes.push_back(s);
		// open: id 127, header of length one, absent slot, two-byte header,
		// absent slot, one column named "ab"
		pend_start = 1'b1;
		pend_op    = 1'b0;
		add_byte(8'h7f);
		add_byte(8'h01);
		add_byte(8'h00);
		add_byte(8'h03);
		add_byte(8'hff);
		add_byte(8'h00);
		add_byte(8'h00);
		add_byte(8'h01);
		add_byte(8'h02);
		add_byte(8'h61);
		add_byte(8'h62);
		// clone cut by end of data on the channel id's last byte
		pend_start = 1'b1;
		pend_op    = 1'b1;
		add_byte(8'h00);
		add_byte(8'h81);
		add_byte(8'h01);
		mark_eod();
		// clone dropped by a new start, which also ends the data
		pend_start = 1'b1;
		pend_op    = 1'b1;
		add_byte(8'h85);
		pend_start = 1'b1;
		pend_op    = 1'b0;
		add_byte(8'h03);
		mark_eod();
		// column count 4097, one above the reset limit
		pend_start = 1'b1;
		pend_op    = 1'b0;
		add_byte(8'h00);
		repeat (4) add_byte(8'h00);
		add_byte(8'h81);
		add_byte(8'h20);
		send_message();
		settle();

		// random messages under several limit settings
		for (int p = 0; p < 5; p++) begin
			case (p)
				1: set_limits(16'd0, 16'd0);
				2: set_limits(16'hffff, 16'hffff);
				3: set_limits(16'd3, 16'd5);
				4: set_limits(($urandom_range(0, 1) != 0) ? 16'($urandom) : 16'($urandom_range(0, 6)),
						($urandom_range(0, 1) != 0) ? 16'($urandom) : 16'($urandom_range(0, 6)));
				default: ;
			endcase
			calm  = (p == 4);
			items = 0;
			while (items < 220) begin
				in_gap_pct  = ($urandom_range(0, 1) != 0) ? 0 : (($urandom_range(0, 1) != 0) ? 5 : 30);
				out_gap_pct = ($urandom_range(0, 1) != 0) ? 0 : (($urandom_range(0, 1) != 0) ? 5 : 30);
				build_message(1'b0);
				items += msg_len;
				send_message();
			end
			// leave the parser at rest before the limits change
			build_message(1'b1);
			send_message();
			settle();
		end

		if (mismatches == 0 && events_due == 0)
			$display("channel_open_message_parser regression: pass");
		else
			$display("channel_open_message_parser regression: fail");
		$finish;
	end

endmodule

>>> channel_open_message_parser.f
design/comp_pkg.sv
design/comp_varint.sv
design/comp_core.sv
design/comp_fifo.sv
design/channel_open_message_parser.sv
tb/sv/open_msg_check.sv
tb/sv/testbench.sv
